/* rtl/sgmt_pkg.sv */
// Shared types and codes for the service group map table.
package sgmt_pkg;

    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_LOOKUP     = 2'd1;
    localparam logic [1:0] ACT_UNREGISTER = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] service_id;
        logic [31:0] group_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_group;
        logic [6:0]  entries_in_use;
    } rsp_t;

endpackage

/* rtl/service_group_map_table.sv */
// Service group map table: top level with entry and group memories and scan control.
//
//  channel   | signals                | handshake
//  ----------+------------------------+-------------------------------------------
//  request   | start, busy, request   | taken on an edge with start high, busy low
//  result    | done, result           | done high for one cycle, cannot be stalled
//
// done follows a scan of the entry memory, read one slot per cycle, then its read
// register, a resolve state and, for a lookup that hits, the group memory read.
// After reset busy stays high while the valid marks are cleared.
// busy drops in the cycle that shows done, so the next request can be taken there.
module service_group_map_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sgmt_pkg::req_t request,
    output logic           done,
    output sgmt_pkg::rsp_t result
);
    import sgmt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;

    // entry word: valid mark over service number
    logic [16:0] ent_mem [TABLE_ENTRIES];
    logic [31:0] grp_mem [TABLE_ENTRIES];
    logic [16:0] ent_rdata_reg;
    logic [31:0] grp_rdata_reg;

    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    logic [16:0]      ent_wdata;
    logic             grp_we;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    req_t             req_reg, req_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;
    logic [CNT_W+6:0] cnt_ext;

    assign cnt_ext = {7'd0, cnt_next};

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (grp_we)
        begin
            grp_mem[free_idx_reg] <= req_reg.group_value;
        end
        grp_rdata_reg <= grp_mem[hit_idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        rd_pend_next    = (state_reg == S_SCAN) && !issue_done_reg;
        rd_idx_next     = scan_idx_reg;
        req_next        = req_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        ent_we          = 1'b0;
        ent_waddr       = scan_idx_reg;
        ent_wdata       = 17'd0;
        grp_we          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ent_we        = 1'b1;
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = request;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (ent_rdata_reg[16] && (ent_rdata_reg[15:0] == req_reg.service_id)
                        && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                    if (!ent_rdata_reg[16] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                rsp_next.status      = ST_OK;
                rsp_next.found_group = 32'd0;
                state_next           = S_IDLE;
                done_next            = 1'b1;
                case (req_reg.action)
                    ACT_REGISTER:
                    begin
                        if (!hit_reg)
                        begin
                            if (free_reg)
                            begin
                                ent_we    = 1'b1;
                                ent_waddr = free_idx_reg;
                                ent_wdata = {1'b1, req_reg.service_id};
                                grp_we    = 1'b1;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = ST_FULL;
                            end
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            state_next = S_FETCH;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    ACT_UNREGISTER:
                    begin
                        if (hit_reg)
                        begin
                            ent_we    = 1'b1;
                            ent_waddr = hit_idx_reg;
                            ent_wdata = {1'b0, req_reg.service_id};
                            cnt_next  = cnt_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.entries_in_use = cnt_ext[6:0];
            end
            S_FETCH:
            begin
                rsp_next.status         = ST_OK;
                rsp_next.found_group    = grp_rdata_reg;
                rsp_next.entries_in_use = cnt_ext[6:0];
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            cnt_reg        <= cnt_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        req_reg      <= req_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

/* rtl/sgmt_checker.sv */
// Port-level checks for the service group map table, bound to the top level.
module sgmt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input sgmt_pkg::rsp_t result
);
    import sgmt_pkg::*;

    // an accepted request keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted request");

    // results never arrive in consecutive cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a result comes with the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_FULL ||
                  result.status == ST_NOT_FOUND))
        else $error("undefined status code");

    // a nonzero group is only reported by a successful lookup
    a_group_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.found_group != 32'd0)) |-> (result.status == ST_OK))
        else $error("group reported with an error status");

endmodule

bind service_group_map_table sgmt_checker u_sgmt_checker (.*);

/* verif/tb.sv */
// Testbench for the service group map table: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb;
    import sgmt_pkg::*;

    localparam int SLOTS = 64;
    localparam int RANDOM_REQUESTS = 780;
    localparam int KEY_POOL = 72;
    localparam logic [1:0] ACT_NONE = 2'd3;

    class group_map_board;
        bit          held [SLOTS];
        logic [15:0] held_service [SLOTS];
        logic [31:0] held_group [SLOTS];
        int unsigned used;
        rsp_t        awaited [$];
        int          mismatches;

        function int find_service(logic [15:0] svc);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held[i] && held_service[i] == svc)
                    return i;
            end
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!held[i])
                    return i;
            end
            return -1;
        endfunction

        function void note(req_t r);
            rsp_t e;
            int   slot;
            e.status = ST_OK;
            e.found_group = '0;
            case (r.action)
                ACT_REGISTER:
                begin
                    if (find_service(r.service_id) < 0)
                    begin
                        slot = find_free();
                        if (slot < 0)
                            e.status = ST_FULL;
                        else
                        begin
                            held[slot] = 1'b1;
                            held_service[slot] = r.service_id;
                            held_group[slot] = r.group_value;
                            used++;
                        end
                    end
                end
                ACT_LOOKUP:
                begin
                    slot = find_service(r.service_id);
                    if (slot < 0)
                        e.status = ST_NOT_FOUND;
                    else
                        e.found_group = held_group[slot];
                end
                ACT_UNREGISTER:
                begin
                    slot = find_service(r.service_id);
                    if (slot >= 0)
                    begin
                        held[slot] = 1'b0;
                        if (used > 0)
                            used--;
                    end
                end
                default:
                begin
                end
            endcase
            e.entries_in_use = used[6:0];
            awaited.push_back(e);
        endfunction

        function void check(rsp_t got);
            rsp_t e;
            if (awaited.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d group %h count %0d",
                             got.status, got.found_group, got.entries_in_use);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (got.status !== e.status || got.found_group !== e.found_group ||
                got.entries_in_use !== e.entries_in_use)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected status %0d group %h count %0d,",
                              " got status %0d group %h count %0d"},
                             e.status, e.found_group, e.entries_in_use,
                             got.status, got.found_group, got.entries_in_use);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    group_map_board board = new();
    logic [15:0] keys [KEY_POOL];

    service_group_map_table #(
        .TABLE_ENTRIES(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check(result);
    end

    task send(input req_t r);
        @(negedge clk);
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        board.note(r);
    endtask

    task put(input logic [1:0] act, input logic [15:0] svc, input logic [31:0] grp);
        req_t r;
        r.action = act;
        r.service_id = svc;
        r.group_value = grp;
        send(r);
    endtask

    task idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task drain();
        idle(1);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // filling stretches lean on register, emptying stretches on unregister
    task run_phase(input int count, input int idle_pct);
        req_t r;
        int   roll;
        bit   filling;
        for (int i = 0; i < count; i++)
        begin
            filling = (i % 120) < 80;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                r.action = ACT_NONE;
            else if (roll < (filling ? 60 : 20))
                r.action = ACT_REGISTER;
            else if (roll < (filling ? 85 : 40))
                r.action = ACT_LOOKUP;
            else
                r.action = ACT_UNREGISTER;
            if ($urandom_range(0, 9) == 0)
                r.service_id = 16'($urandom());
            else
                r.service_id = keys[$urandom_range(0, KEY_POOL - 1)];
            r.group_value = $urandom();
            if (i == count / 2)
                drain();
            // hold off on ready cycles with the given share
            if (idle_pct > 0)
            begin
                idle(1);
                while (busy)
                    idle(1);
                while (int'($urandom_range(0, 99)) < idle_pct)
                    idle(1);
            end
            send(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        for (int k = 0; k < KEY_POOL; k++)
            keys[k] = 16'($urandom());
        keys[0] = 16'h0000;
        keys[1] = 16'hFFFF;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put(ACT_LOOKUP, 16'h0000, 32'h0000_0000);
        put(ACT_UNREGISTER, 16'hFFFF, 32'hFFFF_FFFF);
        put(ACT_NONE, 16'h1234, 32'hDEAD_BEEF);
        put(ACT_REGISTER, 16'h0000, 32'h0000_0000);
        put(ACT_REGISTER, 16'hFFFF, 32'hFFFF_FFFF);
        put(ACT_REGISTER, 16'h0000, 32'h1234_5678);
        put(ACT_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        put(ACT_LOOKUP, 16'hFFFF, 32'h0000_0000);
        put(ACT_REGISTER, 16'h1234, 32'hA5A5_A5A5);
        put(ACT_UNREGISTER, 16'h0000, 32'h0000_0000);
        put(ACT_LOOKUP, 16'h0000, 32'h0000_0000);
        put(ACT_REGISTER, 16'h5555, 32'h5A5A_5A5A);
        put(ACT_LOOKUP, 16'h5555, 32'h0000_0000);
        put(ACT_LOOKUP, 16'h1234, 32'h0000_0000);
        put(ACT_UNREGISTER, 16'h5555, 32'h0000_0000);
        put(ACT_UNREGISTER, 16'h5555, 32'h0000_0000);
        put(ACT_UNREGISTER, 16'h1234, 32'h0000_0000);
        put(ACT_UNREGISTER, 16'hFFFF, 32'h0000_0000);
        put(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF);

        run_phase(RANDOM_REQUESTS / 3, 25);
        run_phase(RANDOM_REQUESTS / 3, 68);
        run_phase(RANDOM_REQUESTS / 3, 0);

        drain();
        repeat (SLOTS + 8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
